### rtl/sswm_pkg.sv
package sswm_pkg;

  localparam int TABLE_DEPTH_DEF = 16384;
  localparam int QUEUE_DEPTH     = 4;

  localparam int ADDR_W = 47;
  localparam int WORD_W = 64;
  localparam int CNT_W  = 15;
  localparam int PIDX_W = 14;
  localparam int REG_W  = 64;
  localparam int CIDX_W = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 15'd10000;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SCAN  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CIDX_W-1:0] REG_EXACT_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MATCH_VALUE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_RESULT_LIMIT = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCAN_EXACT,
    OP_SCAN_SET,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] load_key;
    logic [WORD_W-1:0] word_value;
    logic [ADDR_W-1:0] word_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] found_address;
    logic [PIDX_W-1:0] parent_index;
    logic [CNT_W-1:0]  match_number;
    logic              limit_reached;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] address;
    logic              exact_hit;
    logic              wide;
  } cmd_t;

endpackage

### rtl/sorted_set_word_scan_matcher_core.sv
// Sorted-set word scan matcher.
// Input beats are commands: load a key (appended to the table, which must be
// filled in ascending order), scan a word, or clear the table and counts. A
// beat is taken on a clock edge with start high and busy low; busy rises only
// when the command queue between the front and the back is full.
// A scan that matches gives one result beat: out_valid is high for exactly one
// cycle with out_item; the receiver cannot hold it off. In exact mode a word
// matches the configured value; otherwise the back binary-searches the table
// with one memory probe per cycle.
// A set-mode search makes at most clog2(TABLE_DEPTH) + 1 probes, 15 at the
// default depth. Loads, clears and exact scans drain one per cycle while the
// back is idle; a set scan that searches holds the back in its probe state
// until the search ends, since the key memory has a single read port.
// Results stop once result_limit matches are reported.
// The configuration port writes one register per cycle with cfg_we; write it
// only while no command is in flight.
// Reset (rst_n low, synchronous) empties the queue, zeroes key and match
// counts and restores exact_mode 1, match_value 0, result_limit 10000.
module sorted_set_word_scan_matcher_core #(
  parameter int TABLE_DEPTH = sswm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sswm_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output sswm_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [sswm_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [sswm_pkg::REG_W-1:0]      cfg_wdata
);

  logic                          exact_mode_r;
  logic [sswm_pkg::WORD_W-1:0]   match_value_r;
  sswm_pkg::cnt_t                result_limit_r;

  logic                          push;
  logic                          pop;
  logic                          q_full;
  logic                          q_empty;
  sswm_pkg::cmd_t                wr_cmd;
  sswm_pkg::cmd_t                rd_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_mode_r   <= 1'b1;
      match_value_r  <= '0;
      result_limit_r <= sswm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sswm_pkg::REG_EXACT_MODE:   exact_mode_r   <= cfg_wdata[0];
        sswm_pkg::REG_MATCH_VALUE:  match_value_r  <= cfg_wdata;
        sswm_pkg::REG_RESULT_LIMIT: result_limit_r <= cfg_wdata[sswm_pkg::CNT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  sswm_front u_front (
    .in_item     (in_item),
    .start       (start),
    .q_full      (q_full),
    .exact_mode  (exact_mode_r),
    .match_value (match_value_r),
    .busy        (busy),
    .push        (push),
    .cmd         (wr_cmd)
  );

  sswm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  sswm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (rd_cmd),
    .q_empty      (q_empty),
    .result_limit (result_limit_r),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

### rtl/sswm_front.sv
module sswm_front (
  input  sswm_pkg::in_item_t            in_item,
  input  logic                          start,
  input  logic                          q_full,
  input  logic                          exact_mode,
  input  logic [sswm_pkg::WORD_W-1:0]   match_value,
  output logic                          busy,
  output logic                          push,
  output sswm_pkg::cmd_t                cmd
);

  logic accept;
  logic known;

  assign busy   = q_full;
  assign accept = start && !q_full;

  always_comb begin
    cmd           = '0;
    known         = 1'b1;
    cmd.address   = in_item.word_address;
    cmd.exact_hit = (in_item.word_value == match_value);
    // Bits above the key width keep a word out of the table
    cmd.wide      = |in_item.word_value[sswm_pkg::WORD_W-1:sswm_pkg::ADDR_W];
    cmd.key       = in_item.word_value[sswm_pkg::ADDR_W-1:0];
    unique case (in_item.action)
      sswm_pkg::ACT_LOAD: begin
        cmd.op  = sswm_pkg::OP_LOAD;
        cmd.key = in_item.load_key;
      end
      sswm_pkg::ACT_SCAN: begin
        cmd.op = exact_mode ? sswm_pkg::OP_SCAN_EXACT : sswm_pkg::OP_SCAN_SET;
      end
      sswm_pkg::ACT_CLEAR: begin
        cmd.op = sswm_pkg::OP_CLEAR;
      end
      default: begin
        cmd.op = sswm_pkg::OP_CLEAR;
        known  = 1'b0;
      end
    endcase
  end

  // Drop unused action codes here
  assign push = accept && known;

endmodule

### rtl/sswm_queue.sv
module sswm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sswm_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output sswm_pkg::cmd_t rd_cmd,
  output logic           empty,
  output logic           full
);

  localparam int DEPTH = sswm_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  sswm_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (PW+1)'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### rtl/sswm_back.sv
module sswm_back #(
  parameter int TABLE_DEPTH = sswm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sswm_pkg::cmd_t               cmd,
  input  logic                         q_empty,
  input  sswm_pkg::cnt_t               result_limit,
  output logic                         pop,
  output logic                         out_valid,
  output sswm_pkg::out_item_t          out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KW = $clog2(TABLE_DEPTH + 1);

  typedef logic [KW-1:0] kidx_t;
  typedef enum logic {S_IDLE, S_PROBE} state_t;

  function automatic kidx_t mid_of(input kidx_t lo, input kidx_t hi_ex);
    return lo + ((hi_ex - lo - kidx_t'(1)) >> 1);
  endfunction

  logic [sswm_pkg::ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [sswm_pkg::ADDR_W-1:0] rd_data_r;

  state_t                state_r, state_nxt;
  kidx_t                 lo_r, lo_nxt;
  kidx_t                 hi_r, hi_nxt;
  kidx_t                 mid_r, mid_nxt;
  kidx_t                 key_count_r, key_count_nxt;
  sswm_pkg::cnt_t        match_count_r, match_count_nxt;
  sswm_pkg::addr_t       word_r, word_nxt;
  sswm_pkg::addr_t       addr_r, addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sswm_pkg::out_item_t   out_item_r, out_item_nxt;

  logic                  mem_we;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  below_limit;
  logic                  key_eq, key_lt;
  kidx_t                 lo_up, mid_up, mid_dn;
  logic                  up_empty, dn_empty;
  sswm_pkg::cnt_t        count_inc;

  assign below_limit = (match_count_r < result_limit);
  assign count_inc   = match_count_r + 1'b1;
  assign key_eq      = (rd_data_r == word_r);
  assign key_lt      = (rd_data_r < word_r);
  assign lo_up       = mid_r + kidx_t'(1);
  assign up_empty    = (lo_up >= hi_r);
  assign dn_empty    = (lo_r >= mid_r);
  // Work out both next probes alongside the compare, then pick one
  assign mid_up      = mid_of(lo_up, hi_r);
  assign mid_dn      = mid_of(lo_r, mid_r);

  always_comb begin
    state_nxt       = state_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    key_count_nxt   = key_count_r;
    match_count_nxt = match_count_r;
    word_nxt        = word_r;
    addr_nxt        = addr_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    pop             = 1'b0;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (cmd.op)
            sswm_pkg::OP_LOAD: begin
              if (key_count_r < kidx_t'(TABLE_DEPTH)) begin
                mem_we        = 1'b1;
                key_count_nxt = key_count_r + kidx_t'(1);
              end
            end
            sswm_pkg::OP_CLEAR: begin
              key_count_nxt   = '0;
              match_count_nxt = '0;
            end
            sswm_pkg::OP_SCAN_EXACT: begin
              if (below_limit && cmd.exact_hit) begin
                match_count_nxt            = count_inc;
                out_valid_nxt              = 1'b1;
                out_item_nxt.found_address = cmd.address;
                out_item_nxt.parent_index  = '0;
                out_item_nxt.match_number  = count_inc;
                out_item_nxt.limit_reached = (count_inc >= result_limit);
              end
            end
            sswm_pkg::OP_SCAN_SET: begin
              if (below_limit && !cmd.wide && key_count_r != '0) begin
                lo_nxt    = '0;
                hi_nxt    = key_count_r;
                mid_nxt   = mid_of('0, key_count_r);
                word_nxt  = cmd.key;
                addr_nxt  = cmd.address;
                rd_en     = 1'b1;
                state_nxt = S_PROBE;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          match_count_nxt            = count_inc;
          out_valid_nxt              = 1'b1;
          out_item_nxt.found_address = addr_r;
          out_item_nxt.parent_index  = sswm_pkg::pidx_t'(mid_r);
          out_item_nxt.match_number  = count_inc;
          out_item_nxt.limit_reached = (count_inc >= result_limit);
          state_nxt                  = S_IDLE;
        end else if (key_lt) begin
          lo_nxt = lo_up;
          if (up_empty) begin
            state_nxt = S_IDLE;
          end else begin
            mid_nxt = mid_up;
            rd_en   = 1'b1;
          end
        end else begin
          hi_nxt = mid_r;
          if (dn_empty) begin
            state_nxt = S_IDLE;
          end else begin
            mid_nxt = mid_dn;
            rd_en   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = mid_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      key_count_r   <= '0;
      match_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      key_count_r   <= key_count_nxt;
      match_count_r <= match_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    word_r     <= word_nxt;
    addr_r     <= addr_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[key_count_r[AW-1:0]] <= cmd.key;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> (lo_r <= mid_r) && (mid_r < hi_r))
    else $error("probe index outside search window");

  a_window_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> hi_r <= key_count_r)
    else $error("search window beyond loaded keys");

  a_no_pop_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> !pop)
    else $error("queue popped during a search");

  a_count_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (match_count_r != '0) && (out_item_r.match_number == match_count_r))
    else $error("result number out of step with match count");

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= kidx_t'(TABLE_DEPTH))
    else $error("key count beyond table depth");

endmodule

### dv/sorted_set_word_scan_matcher_core_test.sv
`timescale 1ns / 1ps

module sorted_set_word_scan_matcher_core_test;
  import sswm_pkg::*;

  localparam int         TB_DEPTH    = TABLE_DEPTH_DEF;
  localparam int         DRAIN       = 96;
  localparam int         STALL_MAX   = 1000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_BEATS = 66;
  localparam int         BURST       = 8;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  class match_ledger;
    logic              exact_mode;
    logic [WORD_W-1:0] match_value;
    cnt_t              result_limit;
    addr_t             keys [TB_DEPTH];
    int unsigned       key_count;
    int unsigned       match_count;
    out_item_t         awaited_matches [$];
    int unsigned       errors;

    function new();
      exact_mode   = 1'b1;
      match_value  = '0;
      result_limit = LIMIT_RESET;
      key_count    = 0;
      match_count  = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        REG_EXACT_MODE:   exact_mode = data[0];
        REG_MATCH_VALUE:  match_value = data;
        REG_RESULT_LIMIT: result_limit = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Inclusive bounds, first equal probe wins, table order not checked.
    function bit find_key(logic [WORD_W-1:0] word, output int unsigned pos);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = int'(key_count) - 1;
      pos = 0;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if ({17'b0, keys[mid]} == word) begin
          pos = mid;
          return 1'b1;
        end
        if ({17'b0, keys[mid]} < word) lo = mid + 1;
        else hi = mid - 1;
      end
      return 1'b0;
    endfunction

    function void take_beat(in_item_t b);
      out_item_t   want;
      bit          hit;
      int unsigned pos;
      hit = 1'b0;
      pos = 0;
      case (b.action)
        ACT_LOAD: begin
          if (key_count < TB_DEPTH) begin
            keys[key_count] = b.load_key;
            key_count++;
          end
        end
        ACT_CLEAR: begin
          key_count   = 0;
          match_count = 0;
        end
        ACT_SCAN: begin
          if (match_count < result_limit) begin
            if (exact_mode) hit = (b.word_value == match_value);
            else hit = find_key(b.word_value, pos);
            if (hit) begin
              match_count++;
              want.found_address = b.word_address;
              want.parent_index  = pidx_t'(pos);
              want.match_number  = cnt_t'(match_count);
              want.limit_reached = (match_count >= result_limit);
              awaited_matches.push_back(want);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_match(out_item_t got);
      out_item_t want;
      if (awaited_matches.size() == 0) begin
        $display("%0t: match beat expected none got %h", $time, got);
        errors++;
        return;
      end
      want = awaited_matches.pop_front();
      compare_field("found_address", 64'(want.found_address), 64'(got.found_address));
      compare_field("parent_index", 64'(want.parent_index), 64'(got.parent_index));
      compare_field("match_number", 64'(want.match_number), 64'(got.match_number));
      compare_field("limit_reached", 64'(want.limit_reached), 64'(got.limit_reached));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [REG_W-1:0]  cfg_wdata;

  match_ledger       ledger = new();
  int unsigned       quiet_cycles = 0;
  int unsigned       beats_sent = 0;
  logic              cur_exact = 1'b1;
  logic [WORD_W-1:0] cur_value = '0;
  addr_t             stim_keys [$];
  cnt_t              phase_limit [PHASES] = '{15'h7FFF, 15'd1, 15'd6, LIMIT_RESET,
                                              15'd16384, 15'd3, 15'd2, 15'd40};

  sorted_set_word_scan_matcher_core #(
    .TABLE_DEPTH(TB_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track accepted beats and match beats; end the run if everything stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_match(out_item);
      if (start && !busy) ledger.take_beat(in_item);
      if (out_valid || (start && !busy) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic addr_t rand47();
    return addr_t'({$urandom, $urandom});
  endfunction

  function automatic in_item_t make_beat(input logic [1:0] action, input addr_t key,
                                         input logic [WORD_W-1:0] word, input addr_t addr);
    in_item_t b;
    b.action       = action;
    b.load_key     = key;
    b.word_value   = word;
    b.word_address = addr;
    return b;
  endfunction

  task automatic drive_beat(input in_item_t beat);
    int unsigned gap_pct;
    gap_pct = (beats_sent < 185) ? 31 : (beats_sent < 370) ? 52 : 0;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Hold off until every expected match is out, then let the back drain.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.awaited_matches.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic configure(input logic exact, input logic [WORD_W-1:0] value,
                           input cnt_t limit);
    logic [REG_W-1:0] noise;
    logic [REG_W-1:0] mode_word;
    logic [REG_W-1:0] limit_word;
    noise      = rand64();
    mode_word  = {noise[REG_W-1:1], exact};
    limit_word = {noise[REG_W-1:CNT_W], limit};
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_EXACT_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_index <= REG_MATCH_VALUE;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_index <= REG_RESULT_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_reg(REG_EXACT_MODE, mode_word);
    ledger.set_reg(REG_MATCH_VALUE, value);
    ledger.set_reg(REG_RESULT_LIMIT, limit_word);
    cur_exact = exact;
    cur_value = value;
  endtask

  task automatic run_directed();
    // Reset settings: exact compare against zero
    drive_beat(make_beat(ACT_SCAN, '1, '0, '0));
    drive_beat(make_beat(ACT_SCAN, '0, '0, '1));
    drive_beat(make_beat(ACT_SCAN, rand47(), '1, rand47()));
    drive_beat(make_beat(ACT_NONE, rand47(), '0, rand47()));
    drive_beat(make_beat(ACT_LOAD, '0, rand64(), rand47()));

    configure(1'b0, '1, LIMIT_RESET);
    drive_beat(make_beat(ACT_CLEAR, rand47(), rand64(), rand47()));
    drive_beat(make_beat(ACT_LOAD, 47'd0, rand64(), rand47()));
    drive_beat(make_beat(ACT_LOAD, 47'd3, rand64(), rand47()));
    drive_beat(make_beat(ACT_LOAD, 47'd1000, rand64(), rand47()));
    drive_beat(make_beat(ACT_LOAD, 47'h4000_0000_0000, rand64(), rand47()));
    drive_beat(make_beat(ACT_LOAD, '1, rand64(), rand47()));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'd0, rand47()));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'h0000_7FFF_FFFF_FFFF, '1));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'd1000, rand47()));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'd5, rand47()));
    // low bits equal a key, but the upper bits keep it out of the table
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'h8000_0000_0000_0003, rand47()));
    // out of order key after the largest one
    drive_beat(make_beat(ACT_LOAD, 47'd2, rand64(), rand47()));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'd2, rand47()));
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'd3, rand47()));

    configure(1'b1, '1, 15'd2);
    drive_beat(make_beat(ACT_CLEAR, rand47(), rand64(), rand47()));
    repeat (3) drive_beat(make_beat(ACT_SCAN, rand47(), '1, rand47()));

    // a limit of zero reports nothing
    configure(1'b1, 64'h8000_0000_0000_0000, '0);
    drive_beat(make_beat(ACT_SCAN, rand47(), 64'h8000_0000_0000_0000, rand47()));
  endtask

  task automatic load_next();
    addr_t key;
    if (stim_keys.size() == 0 || $urandom_range(7) == 0)
      key = rand47() >> $urandom_range(46);
    else
      key = stim_keys[$] + addr_t'($urandom_range(1, 1 << $urandom_range(30)));
    drive_beat(make_beat(ACT_LOAD, key, rand64(), rand47()));
    if (stim_keys.size() < TB_DEPTH) stim_keys.push_back(key);
  endtask

  task automatic run_random(input int n);
    int                i;
    int unsigned       r;
    int unsigned       pick;
    addr_t             key;
    logic [WORD_W-1:0] word;
    i = 0;
    while (i < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        drive_beat(make_beat(ACT_CLEAR, rand47(), rand64(), rand47()));
        stim_keys.delete();
        i++;
      end else if (r < 10) begin
        drive_beat(make_beat(ACT_NONE, rand47(), rand64(), rand47()));
        i++;
      end else if (r < 11) begin
        // burst of loads, back to back when the sender does not idle
        repeat (BURST) load_next();
        i += BURST;
      end else if (r < 32) begin
        load_next();
        i++;
      end else begin
        pick = $urandom_range(9);
        key  = (stim_keys.size() != 0) ?
               stim_keys[$urandom_range(stim_keys.size() - 1)] : rand47();
        if (cur_exact) begin
          word = (pick < 5) ? cur_value : rand64();
        end else begin
          case (pick)
            0, 1, 2, 3, 4: word = {17'b0, key};
            5: begin
              word = rand64();
              word[ADDR_W-1:0] = key;
            end
            6: word = {17'b0, key + 47'd1};
            default: word = rand64() >> $urandom_range(63);
          endcase
        end
        drive_beat(make_beat(ACT_SCAN, rand47(), word, rand47()));
        i++;
      end
    end
  endtask

  initial begin
    int ph;
    logic [WORD_W-1:0] value;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: value = '0;
        1: value = '1;
        default: value = rand64();
      endcase
      configure(ph[0], value, phase_limit[ph]);
      run_random(PHASE_BEATS);
    end
    settle();
    if (ledger.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
